>>> hw/rtl/cpwm_pkg.sv
// shared types and constants for the charlieplexed pwm scanner
`timescale 1ns / 1ps

package cpwm_pkg;

  localparam int PIN_COUNT   = 8;
  localparam int PIN_W       = $clog2(PIN_COUNT);
  localparam int GROUP_WIDTH = 3;
  localparam int DUTY_IN_W   = 8;

  // operation codes of an input beat
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef logic [PIN_COUNT-1:0] pin_vec_t;
  typedef logic [PIN_W-1:0]     pin_idx_t;

  // pin state as seen on the result channel
  typedef struct packed {
    pin_vec_t drive;
    pin_vec_t level;
    pin_idx_t row;
  } pin_state_t;

endpackage

>>> hw/rtl/cpwm_frame_store.sv
// frame store: one saturated duty per low pin / high pin pair
`timescale 1ns / 1ps

module cpwm_frame_store #(
  parameter int PWM_STEPS = 16,
  localparam int DUTY_W   = $clog2(PWM_STEPS + 1)
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           wr_en,
  input  cpwm_pkg::pin_idx_t                             wr_low,
  input  cpwm_pkg::pin_idx_t                             wr_high,
  input  logic [cpwm_pkg::DUTY_IN_W-1:0]                 wr_duty,
  input  cpwm_pkg::pin_idx_t                             rd_row,
  input  logic                                           rd_grp,
  output logic [cpwm_pkg::GROUP_WIDTH-1:0][DUTY_W-1:0]   rd_duty
);

  localparam int GW      = cpwm_pkg::GROUP_WIDTH;
  localparam int LANE_W  = $clog2(GW);
  localparam int ENTRIES = 2 * cpwm_pkg::PIN_COUNT;

  // one entry per row and column group, one lane per group column
  // pins above the second group never act as columns and are not kept
  logic [ENTRIES-1:0][GW-1:0][DUTY_W-1:0] duty_r;
  logic [DUTY_W-1:0] sat_duty;
  logic              wr_hit;
  logic              wr_grp;
  logic [LANE_W-1:0] wr_lane;

  // clamp to the period
  always_comb begin
    if (wr_duty > cpwm_pkg::DUTY_IN_W'(PWM_STEPS)) begin
      sat_duty = DUTY_W'(PWM_STEPS);
    end else begin
      sat_duty = wr_duty[DUTY_W-1:0];
    end
  end

  // high pin to group and lane
  always_comb begin
    wr_hit  = 1'b1;
    wr_grp  = 1'b0;
    wr_lane = LANE_W'(wr_high);
    if (wr_high >= cpwm_pkg::PIN_W'(2 * GW)) begin
      wr_hit = 1'b0;
    end else if (wr_high >= cpwm_pkg::PIN_W'(GW)) begin
      wr_grp  = 1'b1;
      wr_lane = LANE_W'(wr_high - cpwm_pkg::PIN_W'(GW));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= '0;
    end else if (wr_en && wr_hit) begin
      duty_r[{wr_low, wr_grp}][wr_lane] <= sat_duty;
    end
  end

  assign rd_duty = duty_r[{rd_row, rd_grp}];

endmodule

>>> hw/rtl/cpwm_scan_engine.sv
// scan engine: pwm phase, row and group counters, snapshot and pin state
`timescale 1ns / 1ps

module cpwm_scan_engine #(
  parameter int PWM_STEPS = 16,
  localparam int DUTY_W   = $clog2(PWM_STEPS + 1)
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           tick,
  output cpwm_pkg::pin_idx_t                             rd_row,
  output logic                                           rd_grp,
  input  logic [cpwm_pkg::GROUP_WIDTH-1:0][DUTY_W-1:0]   rd_duty,
  output cpwm_pkg::pin_state_t                           pins_nxt
);

  localparam int GW = cpwm_pkg::GROUP_WIDTH;

  logic [DUTY_W-1:0]          phase_r, phase_nxt, phase_inc;
  cpwm_pkg::pin_idx_t         row_r, row_nxt, row_new;
  logic                       grp_r, grp_nxt, grp_new;
  logic [GW-1:0][DUTY_W-1:0]  snap_r, snap_nxt, snap_new;
  cpwm_pkg::pin_vec_t         drive_r, drive_nxt;
  cpwm_pkg::pin_vec_t         level_r, level_nxt;
  logic                       wrap;
  logic [2*cpwm_pkg::PIN_COUNT-1:0] pass_cur, pass_new;

  function automatic cpwm_pkg::pin_idx_t group_col(input logic grp, input int k);
    return grp ? cpwm_pkg::PIN_W'(GW + k) : cpwm_pkg::PIN_W'(k);
  endfunction

  // one sweep over the active group columns at a given phase
  function automatic logic [2*cpwm_pkg::PIN_COUNT-1:0] phase_pass(
    input logic [DUTY_W-1:0]         ph,
    input logic [GW-1:0][DUTY_W-1:0] sn,
    input cpwm_pkg::pin_idx_t        row,
    input logic                      grp,
    input cpwm_pkg::pin_vec_t        drv,
    input cpwm_pkg::pin_vec_t        lvl
  );
    cpwm_pkg::pin_idx_t col;
    cpwm_pkg::pin_vec_t d;
    cpwm_pkg::pin_vec_t l;
    d = drv;
    l = lvl;
    for (int k = 0; k < GW; k++) begin
      col = group_col(grp, k);
      if (col != row) begin
        if (ph == sn[k]) begin
          if (ph != '0) begin
            d[col] = 1'b0;
            l[col] = 1'b0;
          end
        end else if (ph == '0) begin
          d[row] = 1'b1;
          l[row] = 1'b0;
          d[col] = 1'b1;
          l[col] = 1'b1;
        end
      end
    end
    return {d, l};
  endfunction

  always_comb begin
    phase_inc = phase_r + DUTY_W'(1);
    wrap      = (phase_inc == DUTY_W'(PWM_STEPS));
    row_new   = row_r + cpwm_pkg::PIN_W'(1);
    grp_new   = grp_r ^ (row_new == '0);
    snap_new  = rd_duty;
    pass_cur = phase_pass(phase_r, snap_r, row_r, grp_r, drive_r, level_r);
    pass_new = phase_pass('0, snap_new, row_new, grp_new, '0, '0);

    phase_nxt = phase_r;
    row_nxt   = row_r;
    grp_nxt   = grp_r;
    snap_nxt  = snap_r;
    drive_nxt = drive_r;
    level_nxt = level_r;
    if (tick) begin
      if (wrap) begin
        // end of period: new row, snapshot and phase 0 in one go
        phase_nxt = DUTY_W'(1);
        row_nxt   = row_new;
        grp_nxt   = grp_new;
        snap_nxt  = snap_new;
        {drive_nxt, level_nxt} = pass_new;
      end else begin
        phase_nxt = phase_inc;
        {drive_nxt, level_nxt} = pass_cur;
      end
    end
  end

  assign rd_row         = row_new;
  assign rd_grp         = grp_new;
  assign pins_nxt.drive = drive_nxt;
  assign pins_nxt.level = level_nxt;
  assign pins_nxt.row   = row_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      row_r   <= '0;
      grp_r   <= 1'b0;
      snap_r  <= '0;
      drive_r <= '0;
      level_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      grp_r   <= grp_nxt;
      snap_r  <= snap_nxt;
      drive_r <= drive_nxt;
      level_r <= level_nxt;
    end
  end

`ifndef SYNTHESIS
  a_level_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r & ~drive_r) == '0) else $error("level set on released pin");

  a_phase_in_period: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < DUTY_W'(PWM_STEPS)) else $error("phase beyond period");

  a_row_low_when_lit: assert property (@(posedge clk) disable iff (!rst_n)
    drive_r != '0 |-> drive_r[row_r] && !level_r[row_r])
    else $error("columns lit without row pin low");

  a_row_moves_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !tick |=> $stable(row_r) && $stable(phase_r))
    else $error("scan advanced without a tick");
`endif

endmodule

>>> hw/rtl/charlieplex_pwm_scanner_top.sv
// top level of the charlieplexed led matrix pwm scanner
`timescale 1ns / 1ps

// usage:
//   input channel (in_valid / in_stall) carries one beat per operation:
//   a tick (in_operation = 0) advances the pwm phase by one step; a write
//   (in_operation = 1) stores in_duty, clamped to PWM_STEPS, for the led
//   between in_low_pin and in_high_pin.
//   result channel (out_valid / out_stall) returns one beat per input beat:
//   pin drive enables, pin levels and the current row pin, as they stand
//   after that beat was applied.
//   out_valid rises in the cycle after an input beat is accepted; one beat is
//   taken every cycle while in_stall is low, set by the single registered
//   pass through the scan engine and frame store write port.
//   when out_stall holds the result register full, in_stall rises in the
//   same cycle, so no beat is taken until the waiting result leaves.
//   reset clears frame store, row snapshot, phase, row, group, engine pins
//   (released) and out_valid, not out_pins_r; the block takes beats at once.
module charlieplex_pwm_scanner_top #(
  parameter int PWM_STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  cpwm_pkg::pin_idx_t                   in_low_pin,
  input  cpwm_pkg::pin_idx_t                   in_high_pin,
  input  logic [cpwm_pkg::DUTY_IN_W-1:0]       in_duty,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output cpwm_pkg::pin_vec_t                   out_pin_drive,
  output cpwm_pkg::pin_vec_t                   out_pin_level,
  output cpwm_pkg::pin_idx_t                   out_scan_row
);

  localparam int DUTY_W = $clog2(PWM_STEPS + 1);

  logic                                         in_take;
  logic                                         out_valid_r;
  cpwm_pkg::pin_state_t                         out_pins_r;
  cpwm_pkg::pin_state_t                         pins_nxt;
  cpwm_pkg::pin_idx_t                           rd_row;
  logic                                         rd_grp;
  logic [cpwm_pkg::GROUP_WIDTH-1:0][DUTY_W-1:0] rd_duty;

  // the result register frees up in the cycle its beat is taken
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  cpwm_frame_store #(
    .PWM_STEPS (PWM_STEPS)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_take && (in_operation == cpwm_pkg::OP_WRITE)),
    .wr_low  (in_low_pin),
    .wr_high (in_high_pin),
    .wr_duty (in_duty),
    .rd_row  (rd_row),
    .rd_grp  (rd_grp),
    .rd_duty (rd_duty)
  );

  cpwm_scan_engine #(
    .PWM_STEPS (PWM_STEPS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (in_take && (in_operation == cpwm_pkg::OP_TICK)),
    .rd_row   (rd_row),
    .rd_grp   (rd_grp),
    .rd_duty  (rd_duty),
    .pins_nxt (pins_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_pins_r <= pins_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pin_drive = out_pins_r.drive;
  assign out_pin_level = out_pins_r.level;
  assign out_scan_row  = out_pins_r.row;

endmodule
